[src/psrl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psrl_pkg
// Shared constants, types and codes for the per-source hourly rate limiter.
// ----------------------------------------------------------------------------
package psrl_pkg;

  localparam int TABLE_ENTRIES = 1024;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  localparam int KEY_W   = 32;
  localparam int HOUR_W  = 5;
  localparam int COUNT_W = 16;

  typedef enum logic [1:0] {
    STATUS_ALLOWED = 2'd0,
    STATUS_LIMIT   = 2'd1,
    STATUS_FULL    = 2'd2
  } psrl_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_EMIT
  } psrl_state_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [HOUR_W-1:0]  hour;
    logic [COUNT_W-1:0] count;
  } psrl_entry_t;

  localparam int ENTRY_W = $bits(psrl_entry_t);

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    psrl_entry_t       wdata;
    logic              re;
    logic [IDX_W-1:0]  raddr;
  } psrl_ram_req_t;

  typedef struct packed {
    logic              valid;
    logic              allowed;
    psrl_status_t      status;
  } psrl_result_t;

endpackage

[src/psrl_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psrl_req_if
// Request channel: source address, current hour and per-hour limit.
// ----------------------------------------------------------------------------
interface psrl_req_if;
  logic        valid;
  logic        ready;
  logic [31:0] source_address;
  logic [4:0]  hour_now;
  logic [15:0] hour_limit;

  modport source (output valid, source_address, hour_now, hour_limit, input ready);
  modport sink   (input valid, source_address, hour_now, hour_limit, output ready);
endinterface

[src/psrl_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psrl_rsp_if
// Response channel: allowed flag and status code.
// ----------------------------------------------------------------------------
interface psrl_rsp_if;
  logic       valid;
  logic       ready;
  logic       allowed;
  logic [1:0] status;

  modport source (output valid, allowed, status, input ready);
  modport sink   (input valid, allowed, status, output ready);
endinterface

[src/psrl_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psrl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module psrl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/psrl_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psrl_core
// Sequencer that scans the record table one slot a cycle through a shared key
// comparator, updates or inserts (room permitting) the record, forms the result.
// ----------------------------------------------------------------------------
module psrl_core import psrl_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  logic [KEY_W-1:0]    req_key,
  input  logic [HOUR_W-1:0]   req_hour,
  input  logic [COUNT_W-1:0]  req_limit,
  output psrl_ram_req_t       ram_req,
  input  logic [ENTRY_W-1:0]  ram_rdata,
  input  logic                out_free,
  output psrl_result_t        result
);

  psrl_state_t state, state_next;

  logic [KEY_W-1:0]   key;
  logic [HOUR_W-1:0]  hour;
  logic [COUNT_W-1:0] limit;
  logic [CNT_W-1:0]   fill;
  logic [CNT_W-1:0]   scan_idx;
  logic               chk_valid;
  logic [IDX_W-1:0]   chk_idx;
  logic [IDX_W-1:0]   hit_idx;
  logic [HOUR_W-1:0]  ent_hour;
  logic [COUNT_W-1:0] ent_count;
  logic               res_allowed;
  psrl_status_t       res_status;

  psrl_entry_t        rd_ent;
  logic               accept;
  logic               issue;
  logic               match;
  logic               scan_done;
  logic               table_full;
  logic [COUNT_W-1:0] base_count;
  logic               under_limit;
  logic [COUNT_W-1:0] new_count;

  assign rd_ent     = psrl_entry_t'(ram_rdata);
  assign accept     = req_valid && req_ready;
  assign issue      = (state == ST_SCAN) && (scan_idx < fill);
  // one compare per cycle against the word read in the previous cycle
  assign match      = chk_valid && (rd_ent.key == key);
  assign scan_done  = !chk_valid && (scan_idx == fill);
  assign table_full = (fill == CNT_W'(TABLE_ENTRIES));

  // new hour opens a fresh window
  assign base_count  = (ent_hour != hour) ? '0 : ent_count;
  assign under_limit = base_count < limit;
  assign new_count   = under_limit ? base_count + COUNT_W'(1) : base_count;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (match) begin
          state_next = ST_UPDATE;
        end else if (scan_done) begin
          state_next = table_full ? ST_EMIT : ST_UPDATE;
        end
      end
      ST_UPDATE: state_next = ST_EMIT;
      ST_EMIT: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready          = (state == ST_IDLE);
    ram_req.re         = issue;
    ram_req.raddr      = scan_idx[IDX_W-1:0];
    ram_req.we         = (state == ST_UPDATE);
    ram_req.waddr      = hit_idx;
    ram_req.wdata.key  = key;
    ram_req.wdata.hour = hour;
    ram_req.wdata.count = new_count;
    result.valid       = (state == ST_EMIT) && out_free;
    result.allowed     = res_allowed;
    result.status      = res_status;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      fill      <= '0;
      chk_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_SCAN) begin
        chk_valid <= issue;
      end else begin
        chk_valid <= 1'b0;
      end
      if (state == ST_SCAN && !match && scan_done && !table_full) begin
        fill <= fill + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key      <= req_key;
      hour     <= req_hour;
      limit    <= req_limit;
      scan_idx <= '0;
    end else if (issue) begin
      scan_idx <= scan_idx + CNT_W'(1);
    end
    if (issue) begin
      chk_idx <= scan_idx[IDX_W-1:0];
    end
    if (state == ST_SCAN) begin
      if (match) begin
        hit_idx   <= chk_idx;
        ent_hour  <= rd_ent.hour;
        ent_count <= rd_ent.count;
      end else if (scan_done) begin
        // new record goes to the lowest free slot
        hit_idx     <= fill[IDX_W-1:0];
        ent_hour    <= '0;
        ent_count   <= '0;
        res_allowed <= 1'b0;
        res_status  <= STATUS_FULL;
      end
    end
    if (state == ST_UPDATE) begin
      res_allowed <= under_limit;
      res_status  <= under_limit ? STATUS_ALLOWED : STATUS_LIMIT;
    end
  end

endmodule

[src/per_source_hourly_rate_limiter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_source_hourly_rate_limiter
// Fixed-window rate limiter keyed by source address, with a fully
// associative table of per-address records.
// ----------------------------------------------------------------------------
// One request is handled at a time. The records sit in a single-port-read RAM
// and are filled from slot 0 upwards, so the search reads the stored records
// one per cycle and stops at the first key match. A known or new address then
// passes an update state that writes its record before the result is formed,
// while a table-full refusal goes straight to the result. The block is ready
// for the next request from the cycle in which the result appears.
// Unknown addresses are inserted at the lowest free slot; once every slot is
// used, unknown addresses are refused with the table-full status. Records
// are only cleared by reset, which is synchronous. The result waits in
// an output register, so a stalled response does not hold up the search.
module per_source_hourly_rate_limiter import psrl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  psrl_req_if.sink   req,
  psrl_rsp_if.source rsp
);

  psrl_ram_req_t        ram_req;
  logic [ENTRY_W-1:0]   ram_rdata;
  psrl_result_t         result;
  logic                 out_free;
  logic                 out_valid;
  logic                 out_allowed;
  logic [1:0]           out_status;

  assign out_free = !out_valid || rsp.ready;

  psrl_core u_core (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .req_key   (req.source_address),
    .req_hour  (req.hour_now),
    .req_limit (req.hour_limit),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata),
    .out_free  (out_free),
    .result    (result)
  );

  psrl_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (result.valid) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result.valid) begin
      out_allowed <= result.allowed;
      out_status  <= result.status;
    end
  end

  assign rsp.valid   = out_valid;
  assign rsp.allowed = out_allowed;
  assign rsp.status  = out_status;

  a_allowed_status: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.allowed == (rsp.status == STATUS_ALLOWED)))
    else $error("allowed flag disagrees with status");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.status == STATUS_ALLOWED || rsp.status == STATUS_LIMIT ||
                   rsp.status == STATUS_FULL))
    else $error("status code out of range");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request accepted while a search is running");

  a_one_result: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !(rsp.valid && $past(rsp.valid && !rsp.ready) == 1'b0
                                   && !$past(req.ready)))
    else $error("result appeared without a search");

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the per-source hourly rate limiter. A short table of
// directed requests is followed by random traffic on a small set of sources
// that grows now and then. Each verdict is checked against a local model of
// the record table, or against the listed verdict for a typed table row.
// ----------------------------------------------------------------------------
module testbench import psrl_pkg::*; ();

  typedef struct packed {
    logic [KEY_W-1:0]   addr;
    logic [HOUR_W-1:0]  hour;
    logic [COUNT_W-1:0] limit;
  } request_t;

  typedef struct packed {
    logic         allowed;
    psrl_status_t status;
  } verdict_t;

  typedef struct {
    logic [KEY_W-1:0]   addr;
    logic [HOUR_W-1:0]  hour;
    logic [COUNT_W-1:0] limit;
    bit                 typed;
    logic               allowed;
    psrl_status_t       status;
  } plan_row_t;

  typedef enum int {RX_OPEN, RX_LIGHT, RX_HALF, RX_HEAVY} rx_mode_t;

  logic clk = 1'b0;
  logic rst;

  psrl_req_if req ();
  psrl_rsp_if rsp ();

  per_source_hourly_rate_limiter dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // model of the record table
  bit                 rec_valid [TABLE_ENTRIES];
  logic [KEY_W-1:0]   rec_key   [TABLE_ENTRIES];
  logic [HOUR_W-1:0]  rec_hour  [TABLE_ENTRIES];
  logic [COUNT_W-1:0] rec_count [TABLE_ENTRIES];
  int                 rec_used = 0;

  verdict_t         verdict_q [$];
  logic [KEY_W-1:0] pool [$];
  int               mismatches = 0;
  int               burst_left = 0;
  int               clock_hour = 0;
  rx_mode_t         rx_mode = RX_OPEN;
  int               rx_span = 0;
  verdict_t         want;

  plan_row_t plan [16] = '{
    '{32'h0000_0000,  5'd0, 16'h0000, 1'b1, 1'b0, STATUS_LIMIT},
    '{32'h0000_0000,  5'd0, 16'h0001, 1'b1, 1'b1, STATUS_ALLOWED},
    '{32'h0000_0000,  5'd0, 16'h0001, 1'b1, 1'b0, STATUS_LIMIT},
    '{32'h0000_0000,  5'd1, 16'h0001, 1'b1, 1'b1, STATUS_ALLOWED},
    '{32'hFFFF_FFFF,  5'd23, 16'hFFFF, 1'b1, 1'b1, STATUS_ALLOWED},
    '{32'hFFFF_FFFF,  5'd31, 16'h0000, 1'b1, 1'b0, STATUS_LIMIT},
    '{32'hFFFF_FFFF,  5'd31, 16'h0001, 1'b1, 1'b1, STATUS_ALLOWED},
    '{32'h5555_5555,  5'd24, 16'h0002, 1'b1, 1'b1, STATUS_ALLOWED},
    '{32'h5555_5555,  5'd24, 16'h0002, 1'b1, 1'b1, STATUS_ALLOWED},
    '{32'h5555_5555,  5'd24, 16'h0002, 1'b1, 1'b0, STATUS_LIMIT},
    '{32'hAAAA_AAAA,  5'd0, 16'h0003, 1'b1, 1'b1, STATUS_ALLOWED},
    '{32'h0000_0000,  5'd1, 16'h0001, 1'b1, 1'b0, STATUS_LIMIT},
    '{32'h0000_0000,  5'd0, 16'hFFFF, 1'b1, 1'b1, STATUS_ALLOWED},
    '{32'h8000_0000,  5'd16, 16'h0001, 1'b0, 1'b0, STATUS_ALLOWED},
    '{32'h0000_0001,  5'd8, 16'h8000, 1'b0, 1'b0, STATUS_ALLOWED},
    '{32'hAAAA_AAAA,  5'd15, 16'h7FFF, 1'b0, 1'b0, STATUS_ALLOWED}
  };

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic verdict_t predict_verdict(request_t r);
    verdict_t v;
    int hit;
    int spare;
    hit = -1;
    spare = -1;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (rec_valid[i]) begin
        if (hit < 0 && rec_key[i] == r.addr) hit = i;
      end else if (spare < 0) begin
        spare = i;
      end
    end
    if (hit < 0) begin
      if (spare < 0) begin
        v.allowed = 1'b0;
        v.status  = STATUS_FULL;
        return v;
      end
      hit = spare;
      rec_valid[hit] = 1'b1;
      rec_key[hit]   = r.addr;
      rec_hour[hit]  = '0;
      rec_count[hit] = '0;
      rec_used++;
    end
    if (rec_hour[hit] != r.hour) begin
      rec_hour[hit]  = r.hour;
      rec_count[hit] = '0;
    end
    if (rec_count[hit] < r.limit) begin
      rec_count[hit] = rec_count[hit] + COUNT_W'(1);
      v.allowed = 1'b1;
      v.status  = STATUS_ALLOWED;
    end else begin
      v.allowed = 1'b0;
      v.status  = STATUS_LIMIT;
    end
    return v;
  endfunction

  function automatic bit is_known(logic [KEY_W-1:0] a);
    for (int i = 0; i < TABLE_ENTRIES; i++)
      if (rec_valid[i] && rec_key[i] == a) return 1'b1;
    return 1'b0;
  endfunction

  function automatic logic [KEY_W-1:0] fresh_address();
    logic [KEY_W-1:0] a;
    a = $urandom;
    while (is_known(a)) a = $urandom;
    return a;
  endfunction

  // mostly the running hour, which moves on now and then; some stray hours
  function automatic logic [HOUR_W-1:0] pick_hour();
    if ($urandom_range(0, 31) == 0) clock_hour = (clock_hour == 23) ? 0 : clock_hour + 1;
    if ($urandom_range(0, 11) == 0) return HOUR_W'($urandom_range(0, 31));
    return HOUR_W'(clock_hour);
  endfunction

  function automatic logic [COUNT_W-1:0] pick_limit();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return COUNT_W'($urandom_range(0, 16'hFFFF));
      default: return COUNT_W'($urandom_range(1, 4));
    endcase
  endfunction

  task automatic report_mismatch(string what);
    if (mismatches < 200) $display("mismatch at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  task automatic send_request(request_t r, bit typed, logic allowed, psrl_status_t status);
    verdict_t v;
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 10);
      repeat (gap) begin
        @(negedge clk);
        req.valid          <= 1'b0;
        req.source_address <= $urandom;
        req.hour_now       <= HOUR_W'($urandom);
        req.hour_limit     <= COUNT_W'($urandom);
      end
    end
    burst_left--;
    @(negedge clk);
    req.valid          <= 1'b1;
    req.source_address <= r.addr;
    req.hour_now       <= r.hour;
    req.hour_limit     <= r.limit;
    do @(posedge clk); while (!req.ready);
    v = predict_verdict(r);
    if (typed) begin
      v.allowed = allowed;
      v.status  = status;
    end
    verdict_q.push_back(v);
  endtask

  // receiver stalls in stretches of differing density
  always @(negedge clk) begin
    if (rx_span == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_span = $urandom_range(20, 300);
    end else begin
      rx_span--;
    end
    case (rx_mode)
      RX_OPEN:  rsp.ready <= 1'b1;
      RX_LIGHT: rsp.ready <= ($urandom_range(0, 3) != 0);
      RX_HALF:  rsp.ready <= ($urandom_range(0, 1) != 0);
      default:  rsp.ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // one word per verdict, compared with the oldest one pending
  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      if (verdict_q.size() == 0) begin
        report_mismatch($sformatf("unexpected verdict allowed=%0b status=%0d",
                                  rsp.allowed, rsp.status));
      end else begin
        want = verdict_q.pop_front();
        if (rsp.allowed !== want.allowed)
          report_mismatch($sformatf("allowed %0b, wanted %0b", rsp.allowed, want.allowed));
        if (rsp.status !== want.status)
          report_mismatch($sformatf("status %0d, wanted %0d", rsp.status, want.status));
      end
    end
  end

  initial begin
    #100_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    request_t         r;
    rst                = 1'b1;
    req.valid          = 1'b0;
    req.source_address = '0;
    req.hour_now       = '0;
    req.hour_limit     = '0;
    rsp.ready          = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      r.addr  = plan[i].addr;
      r.hour  = plan[i].hour;
      r.limit = plan[i].limit;
      send_request(r, plan[i].typed, plan[i].allowed, plan[i].status);
    end

    foreach (plan[i]) pool.push_back(plan[i].addr);
    for (int k = 0; k < 14; k++) pool.push_back($urandom);
    // near neighbours catch a key compare that ignores some bits
    for (int k = 0; k < 6; k++) pool.push_back(pool[16 + k] ^ (32'h1 << $urandom_range(0, 31)));

    // well-formed traffic on a small table, with the odd new source
    for (int n = 0; n < 564; n++) begin
      r.hour  = pick_hour();
      r.limit = pick_limit();
      if ($urandom_range(0, 9) == 0 && rec_used < 96) begin
        r.addr = fresh_address();
        pool.push_back(r.addr);
      end else begin
        r.addr = pool[$urandom_range(0, pool.size() - 1)];
      end
      send_request(r, 1'b0, 1'b0, STATUS_ALLOWED);
    end

    @(negedge clk);
    req.valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (TABLE_ENTRIES + 64) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
